// ===== rtl/slt_pkg.sv =====
// Shared types, constants and character classes for the stack language tokenizer.
`default_nettype none

package slt_pkg;

	localparam int CFG_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int VALUE_W = 32;

	localparam logic [CFG_W-1:0] MAX_CHARS_RESET = 7'd127;

	localparam logic [CHAR_W-1:0] CH_NUL     = 8'd0;
	localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
	localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
	localparam logic [CHAR_W-1:0] CH_PERCENT = 8'd37;
	localparam logic [CHAR_W-1:0] CH_STAR    = 8'd42;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 8'd43;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
	localparam logic [CHAR_W-1:0] CH_SLASH   = 8'd47;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'd65;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'd90;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'd97;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'd122;

	typedef enum logic [4:0] {
		MODE_IDLE   = 5'b00001,
		MODE_NUMBER = 5'b00010,
		MODE_MINUS  = 5'b00100,
		MODE_SYMBOL = 5'b01000,
		MODE_ERROR  = 5'b10000
	} mode_t;

	typedef enum logic [1:0] {
		KIND_INT = 2'd0,
		KIND_SYM = 2'd1,
		KIND_END = 2'd2,
		KIND_ERR = 2'd3
	} token_kind_t;

	typedef struct packed {
		mode_t               mode;
		logic [VALUE_W-1:0]  acc;
		logic                neg;
		logic [CFG_W-1:0]    len;
		logic [CHAR_W-1:0]   held;
	} state_t;

	localparam state_t STATE_CLEAR = '{
		mode: MODE_IDLE, acc: '0, neg: 1'b0, len: '0, held: '0
	};

	typedef struct packed {
		token_kind_t               kind;
		logic signed [VALUE_W-1:0] value;
		logic                      symbol_end;
		logic                      run_last;
	} token_t;

	// Up to two results per character, already packed in order.
	typedef struct packed {
		logic [1:0] n;
		token_t     r0;
		token_t     r1;
	} push_t;

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [CHAR_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_symch(input logic [CHAR_W-1:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
		       (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
		       (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) ||
		       (c == CH_SLASH) || (c == CH_PERCENT);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/slt_if.sv =====
// Valid/ready channel interfaces for characters in and tokens out.
`default_nettype none

interface slt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface slt_token_if;
	logic               valid;
	logic               ready;
	logic [1:0]         token_kind;
	logic signed [31:0] token_value;
	logic               symbol_end;
	logic               run_last;

	modport source (output valid, output token_kind, output token_value,
		output symbol_end, output run_last, input ready);
	modport sink   (input valid, input token_kind, input token_value,
		input symbol_end, input run_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/slt_step.sv =====
// Next-state and result logic for one text character.
`default_nettype none

module slt_step (
	input  slt_pkg::state_t                st,
	input  logic [slt_pkg::CHAR_W-1:0]     c,
	input  logic [slt_pkg::CFG_W-1:0]      max_chars,
	output slt_pkg::state_t                ns,
	output slt_pkg::push_t                 push
);
	import slt_pkg::*;

	logic                 a_v, b_v;
	token_t               a, b;
	logic                 ts_go, dig_go;
	logic [CFG_W-1:0]     dig_len;
	logic [VALUE_W-1:0]   dig_acc;
	logic                 dig_neg;
	logic [VALUE_W-1:0]   dig_val;
	logic [VALUE_W-1:0]   num_out;
	token_t               r0, r1;

	assign dig_val = {{(VALUE_W-CHAR_W){1'b0}}, c - CH_ZERO};
	assign num_out = st.neg ? (~st.acc + 32'd1) : st.acc;

	always_comb begin
		ns      = st;
		a_v     = 1'b0;
		b_v     = 1'b0;
		a       = '{kind: KIND_INT, value: '0, symbol_end: 1'b0, run_last: 1'b0};
		b       = a;
		ts_go   = 1'b0;
		dig_go  = 1'b0;
		dig_len = st.len;
		dig_acc = st.acc;
		dig_neg = st.neg;

		unique case (st.mode)
			MODE_NUMBER: begin
				if (is_digit(c)) begin
					dig_go = 1'b1;
				end else begin
					a_v   = 1'b1;
					a     = '{kind: KIND_INT, value: $signed(num_out),
						symbol_end: 1'b0, run_last: 1'b0};
					ts_go = 1'b1;
				end
			end
			MODE_MINUS: begin
				if (is_digit(c)) begin
					dig_go  = 1'b1;
					dig_len = 7'd1;
					dig_acc = '0;
					dig_neg = 1'b1;
				end else if (is_symch(c)) begin
					a_v     = 1'b1;
					a       = '{kind: KIND_SYM, value: 32'(CH_MINUS),
						symbol_end: 1'b0, run_last: 1'b0};
					ns.mode = MODE_SYMBOL;
					ns.held = c;
				end else begin
					a_v   = 1'b1;
					a     = '{kind: KIND_SYM, value: 32'(CH_MINUS),
						symbol_end: 1'b1, run_last: 1'b0};
					ts_go = 1'b1;
				end
			end
			MODE_SYMBOL: begin
				a_v = 1'b1;
				a   = '{kind: KIND_SYM, value: 32'(st.held),
					symbol_end: !is_symch(c), run_last: 1'b0};
				if (is_symch(c)) begin
					ns.held = c;
				end else begin
					ts_go = 1'b1;
				end
			end
			MODE_ERROR: begin
				if (c == CH_NUL) begin
					ns  = STATE_CLEAR;
					a_v = 1'b1;
					a   = '{kind: KIND_END, value: '0, symbol_end: 1'b0, run_last: 1'b0};
				end
			end
			MODE_IDLE: begin
				ts_go = 1'b1;
			end
			default: begin
				ts_go = 1'b1;
			end
		endcase

		// start of a new token
		if (ts_go) begin
			ns = STATE_CLEAR;
			if (c == CH_NUL) begin
				b_v = 1'b1;
				b   = '{kind: KIND_END, value: '0, symbol_end: 1'b0, run_last: 1'b0};
			end else if (is_space(c)) begin
				ns.mode = MODE_IDLE;
			end else if (is_digit(c)) begin
				dig_go  = 1'b1;
				dig_len = '0;
				dig_acc = '0;
				dig_neg = 1'b0;
			end else if (c == CH_MINUS) begin
				ns.mode = MODE_MINUS;
			end else if (is_symch(c)) begin
				ns.mode = MODE_SYMBOL;
				ns.held = c;
			end else begin
				ns.mode = MODE_ERROR;
				b_v     = 1'b1;
				b       = '{kind: KIND_ERR, value: '0, symbol_end: 1'b0, run_last: 1'b0};
			end
		end

		// digit append: x10 as two shifts and an add
		if (dig_go) begin
			if (dig_len >= max_chars) begin
				ns      = STATE_CLEAR;
				ns.mode = MODE_ERROR;
				b_v     = 1'b1;
				b       = '{kind: KIND_ERR, value: '0, symbol_end: 1'b0, run_last: 1'b0};
			end else begin
				ns.mode = MODE_NUMBER;
				ns.len  = dig_len + 7'd1;
				ns.acc  = (dig_acc << 3) + (dig_acc << 1) + dig_val;
				ns.neg  = dig_neg;
			end
		end
	end

	always_comb begin
		r0 = a_v ? a : b;
		r1 = b;
		if (a_v && b_v) begin
			r1.run_last = 1'b1;
		end else begin
			r0.run_last = 1'b1;
		end
		push.n  = {1'b0, a_v} + {1'b0, b_v};
		push.r0 = r0;
		push.r1 = r1;
	end

endmodule

`default_nettype wire

// ===== rtl/slt_res_fifo.sv =====
// Four-entry result queue, two pushes and one pop per cycle.
`default_nettype none

module slt_res_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  slt_pkg::push_t push,
	output logic           room,
	output logic           out_valid,
	input  logic           out_ready,
	output slt_pkg::token_t out_data
);
	import slt_pkg::*;

	token_t     mem_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 3'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = (count_q < 3'd3);

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_q + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push.n;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, push.n} - {2'b0, pop};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/stack_language_tokenizer_core.sv =====
// Top level of the streaming stack language tokenizer.
//
//  channel    dir  transfer  payload
//  char_in    in   1 char    char_code[7:0]
//  token_out  out  1 token   token_kind[1:0], token_value[31:0], symbol_end, run_last
//  cfg        in   write     cfg_wdata[6:0] -> max_number_chars (reset 127)
//
// One character per cycle while the queue has room: input register, then scan
// logic (classify, one x10 accumulate) pushing 0..2 tokens into a four-entry queue.
// With the queue empty, a char passes the input register, then the queue as a token.
// Two tokens from one character leave one at a time; the port limits rate then.
// arst_n clears scan state, queue and max_number_chars to 127.
// Input stalls only while the queue has fewer than two free entries.
`default_nettype none

module stack_language_tokenizer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	slt_char_if.sink                     char_in,
	slt_token_if.source                  token_out,
	input  logic                         cfg_we,
	input  logic [slt_pkg::CFG_W-1:0]    cfg_wdata
);
	import slt_pkg::*;

	// input register
	logic [CHAR_W-1:0] char_s1;
	logic              valid_s1;

	// scan state and config
	state_t            state_q, state_next;
	logic [CFG_W-1:0]  max_chars_q;

	push_t             step_push, fifo_push;
	logic              room;
	logic              advance;
	logic              fifo_valid;
	token_t            fifo_data;

	// the held character is scanned once the queue can take both tokens
	assign advance       = valid_s1 && room;
	assign char_in.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_in.valid && char_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_in.valid && char_in.ready) begin
			char_s1 <= char_in.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MAX_CHARS_RESET;
		end else if (cfg_we) begin
			max_chars_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_CLEAR;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	slt_step u_step (
		.st        (state_q),
		.c         (char_s1),
		.max_chars (max_chars_q),
		.ns        (state_next),
		.push      (step_push)
	);

	// nothing enters the queue unless the character is actually consumed
	always_comb begin
		fifo_push   = step_push;
		fifo_push.n = advance ? step_push.n : 2'd0;
	end

	slt_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.room      (room),
		.out_valid (fifo_valid),
		.out_ready (token_out.ready),
		.out_data  (fifo_data)
	);

	assign token_out.valid       = fifo_valid;
	assign token_out.token_kind  = fifo_data.kind;
	assign token_out.token_value = fifo_data.value;
	assign token_out.symbol_end  = fifo_data.symbol_end;
	assign token_out.run_last    = fifo_data.run_last;

`ifndef ASSERT_OFF
	// in error mode only end-of-text produces anything
	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q.mode == MODE_ERROR && char_s1 != CH_NUL)
		|-> (step_push.n == 2'd0))
		else $error("tokens emitted while skipping after a syntax error");

	// an end marker always leaves the scanner idle
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_push.n != 2'd0 && fifo_push.r0.kind == KIND_END) ||
		(fifo_push.n == 2'd2 && fifo_push.r1.kind == KIND_END)
		|=> (state_q.mode == MODE_IDLE))
		else $error("scanner not idle after end marker");

	// a two-token character always ends in end marker or error
	a_pair_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(fifo_push.n == 2'd2)
		|-> (fifo_push.r1.kind == KIND_END || fifo_push.r1.kind == KIND_ERR))
		else $error("unexpected second token for one character");

	// symbol_end only rides on symbol tokens
	a_symend_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(token_out.valid && token_out.symbol_end)
		|-> (token_out.token_kind == KIND_SYM))
		else $error("symbol_end set on a non-symbol token");
`endif

endmodule

`default_nettype wire
